// ===== hdl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Beat structs, entry layout, opcode and status codes, cell control.
// No dependencies.
package spq_pkg;

    localparam int VERTEX_BITS   = 10;
    localparam int PRIORITY_BITS = 32;
    localparam int OPCODE_BITS   = 3;
    localparam int STATUS_BITS   = 2;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_INSERT       = 3'd0,
        OP_EXTRACT_MIN  = 3'd1,
        OP_DECREASE_KEY = 3'd2,
        OP_CONTAINS     = 3'd3,
        OP_GET_PARENT   = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_APPLY
    } state_t;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_SEARCH,
        CM_SHIFT,
        CM_INSERT
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t mode;
        logic       limit;   // decrease-key: only cells up to the hit move
    } cell_ctrl_t;

    typedef struct packed {
        logic [VERTEX_BITS-1:0]          vertex;
        logic signed [PRIORITY_BITS-1:0] priority_key;
        logic [VERTEX_BITS-1:0]          parent;
    } entry_t;

    typedef struct packed {
        logic [OPCODE_BITS-1:0]          opcode;
        logic [VERTEX_BITS-1:0]          node_id;
        logic signed [PRIORITY_BITS-1:0] priority_req;
        logic [VERTEX_BITS-1:0]          parent_id;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic                   found;
        logic [VERTEX_BITS-1:0] out_node;
        logic [VERTEX_BITS-1:0] out_parent;
        logic                   is_empty;
    } rsp_t;

endpackage

// ===== hdl/spq_cell.sv =====
// One slot of the sorted queue row: entry, valid bit and search flags.
// Trades entries with its left and right neighbors. Depends on spq_pkg.
module spq_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  spq_pkg::cell_ctrl_t             ctrl,
    input  logic [spq_pkg::VERTEX_BITS-1:0] node,
    input  spq_pkg::entry_t                 new_entry,
    input  spq_pkg::entry_t                 left_entry,
    input  logic                            left_valid,
    input  logic                            left_ins,
    input  spq_pkg::entry_t                 right_entry,
    input  logic                            right_valid,
    input  logic                            hit_in,
    output spq_pkg::entry_t                 entry,
    output logic                            valid,
    output logic                            ins,
    output logic                            hit_out,
    output spq_pkg::entry_t                 sel_entry,
    output logic                            sel_gt
);
    import spq_pkg::*;

    entry_t entry_reg, entry_next;
    logic   valid_reg, valid_next;
    logic   gt_reg, gt_next;
    logic   first_reg, first_next;
    logic   le_reg, le_next;
    logic   match;

    assign match   = valid_reg && (entry_reg.vertex == node);
    assign hit_out = hit_in || match;

    // Insert slot: for decrease-key stay at or before the hit.
    assign ins = ctrl.limit ? (gt_reg && le_reg) : (gt_reg || !valid_reg);

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        gt_next    = gt_reg;
        first_next = first_reg;
        le_next    = le_reg;
        case (ctrl.mode)
            CM_SEARCH:
            begin
                gt_next    = valid_reg && (entry_reg.priority_key > new_entry.priority_key);
                first_next = match && !hit_in;
                le_next    = !hit_in;
            end
            CM_SHIFT:
            begin
                entry_next = right_entry;
                valid_next = right_valid;
            end
            CM_INSERT:
            begin
                if (ins)
                begin
                    if (left_ins)
                    begin
                        entry_next = left_entry;
                        valid_next = left_valid;
                    end
                    else
                    begin
                        entry_next = new_entry;
                        valid_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            gt_reg    <= 1'b0;
            first_reg <= 1'b0;
            le_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            gt_reg    <= gt_next;
            first_reg <= first_next;
            le_reg    <= le_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry     = entry_reg;
    assign valid     = valid_reg;
    assign sel_entry = first_reg ? entry_reg : '0;
    assign sel_gt    = first_reg && gt_reg;

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// Sorted priority queue with decrease-key, built as a row of spq_cell slots.
// Top level: command capture, sequencing and result beat. Depends on spq_pkg, spq_cell.
//
// Every operation runs a compare step (S_SEARCH) and then an update step (S_APPLY).
// A command beat is taken when start is high and busy is low. In the compare step every
// cell compares its entry against the command at once (vertex match, priority greater
// than the new key) and latches its flags; in the update step the row shifts in one
// step: left for extract-min, right from the insert point for insert, and between the
// new point and the old entry for decrease-key. busy is high only during the compare
// step, so a new command may be issued in the update step. The result beat appears on
// rsp with done high for exactly one cycle, the cycle after the update; the receiver
// cannot stall it, so capture it when done is high. Entries are kept in ascending
// priority order, equal priorities in arrival order, and searches use the matching
// entry nearest the front. CAPACITY sets the number of cells; there is no clearing
// pass after reset.
module sorted_priority_queue #(
    parameter int CAPACITY = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  spq_pkg::cmd_t cmd,
    output logic          done,
    output spq_pkg::rsp_t rsp
);
    import spq_pkg::*;

    state_t     state_reg, state_next;
    cmd_t       cmd_reg;
    rsp_t       rsp_reg, rsp_next;
    logic       done_reg, done_next;
    cell_ctrl_t ctrl;
    logic       accept;

    entry_t               cell_entry [CAPACITY];
    entry_t               cell_sel   [CAPACITY];
    logic [CAPACITY-1:0]  cell_valid;
    logic [CAPACITY-1:0]  cell_ins;
    logic [CAPACITY-1:0]  cell_hit;
    logic [CAPACITY-1:0]  cell_sel_gt;
    entry_t               new_entry;

    entry_t hit_entry;
    logic   hit_found;
    logic   hit_gt;

    assign busy   = (state_reg == S_SEARCH);
    assign accept = start && !busy;

    assign new_entry.vertex       = cmd_reg.node_id;
    assign new_entry.priority_key = cmd_reg.priority_req;
    assign new_entry.parent       = cmd_reg.parent_id;

    // Build the cell row; the ends see an empty neighbor.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t left_e, right_e;
        logic   left_v, left_i, right_v, hit_i;

        if (i == 0)
        begin : g_first
            assign left_e = '0;
            assign left_v = 1'b0;
            assign left_i = 1'b0;
            assign hit_i  = 1'b0;
        end
        else
        begin : g_mid
            assign left_e = cell_entry[i-1];
            assign left_v = cell_valid[i-1];
            assign left_i = cell_ins[i-1];
            assign hit_i  = cell_hit[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_e = '0;
            assign right_v = 1'b0;
        end
        else
        begin : g_inner
            assign right_e = cell_entry[i+1];
            assign right_v = cell_valid[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .node        (cmd_reg.node_id),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .left_valid  (left_v),
            .left_ins    (left_i),
            .right_entry (right_e),
            .right_valid (right_v),
            .hit_in      (hit_i),
            .entry       (cell_entry[i]),
            .valid       (cell_valid[i]),
            .ins         (cell_ins[i]),
            .hit_out     (cell_hit[i]),
            .sel_entry   (cell_sel[i]),
            .sel_gt      (cell_sel_gt[i])
        );
    end

    // Collect the first hit; at most one cell holds its flag.
    always_comb
    begin
        hit_entry = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_entry = hit_entry | cell_sel[i];
        end
    end

    assign hit_found = cell_hit[CAPACITY-1];
    assign hit_gt    = |cell_sel_gt;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (accept) state_next = S_SEARCH;
            S_SEARCH: state_next = S_APPLY;
            S_APPLY:  state_next = accept ? S_SEARCH : S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Outputs: cell control and the result beat.
    always_comb
    begin
        ctrl       = '{mode: CM_HOLD, limit: 1'b0};
        rsp_next   = '0;
        done_next  = 1'b0;
        rsp_next.is_empty = !cell_valid[0];
        unique case (state_reg)
            S_SEARCH:
            begin
                ctrl.mode = CM_SEARCH;
            end
            S_APPLY:
            begin
                done_next = 1'b1;
                unique case (cmd_reg.opcode) inside
                    OP_INSERT:
                    begin
                        if (cell_valid[CAPACITY-1])
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            ctrl.mode         = CM_INSERT;
                            rsp_next.is_empty = 1'b0;
                        end
                    end
                    OP_EXTRACT_MIN:
                    begin
                        if (cell_valid[0])
                        begin
                            ctrl.mode           = CM_SHIFT;
                            rsp_next.out_node   = cell_entry[0].vertex;
                            rsp_next.out_parent = cell_entry[0].parent;
                            rsp_next.is_empty   = !cell_valid[1];
                        end
                        else
                        begin
                            rsp_next.status = ST_EMPTY;
                        end
                    end
                    OP_DECREASE_KEY:
                    begin
                        if (hit_found && hit_gt)
                        begin
                            ctrl.mode  = CM_INSERT;
                            ctrl.limit = 1'b1;
                        end
                        else
                        begin
                            rsp_next.status = ST_MISS;
                        end
                    end
                    OP_CONTAINS, OP_GET_PARENT:
                    begin
                        if (hit_found)
                        begin
                            rsp_next.found = 1'b1;
                            if (cmd_reg.opcode == OP_GET_PARENT)
                            begin
                                rsp_next.out_parent = hit_entry.parent;
                            end
                        end
                        else
                        begin
                            rsp_next.status = ST_MISS;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Hold the command for the compare and update cycles; hold the result beat.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        if (done_next)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
